// ===== rtl/msw_pkg.sv =====
// Shared types and codes for the maze stack walker.
`default_nettype none

package msw_pkg;

  // Command carried in the input beat's tuser
  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_STEP    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  // Cell kinds held in the grid memory
  localparam logic [1:0] KIND_OPEN    = 2'd0;
  localparam logic [1:0] KIND_WALL    = 2'd1;
  localparam logic [1:0] KIND_VISITED = 2'd2;
  localparam logic [1:0] KIND_GOAL    = 2'd3;

  // Result status carried in the output beat's tuser
  localparam logic [1:0] ST_MOVED   = 2'd0;
  localparam logic [1:0] ST_GOAL    = 2'd1;
  localparam logic [1:0] ST_NO_PATH = 2'd2;
  localparam logic [1:0] ST_ACK     = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_START_ROW = 2'd0;
  localparam logic [1:0] CFG_START_COL = 2'd1;
  localparam logic [1:0] CFG_ROWS      = 2'd2;
  localparam logic [1:0] CFG_COLS      = 2'd3;

  // Neighbor search order
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  localparam int unsigned FAIL_W = 16;

endpackage

`default_nettype wire

// ===== rtl/msw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module msw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/maze_stack_walker_core.sv =====
// Depth-first maze walker: grid memory, path stack memory and step sequencer.
//
//  Channel  | Dir | Handshake                 | Payload
//  ---------+-----+---------------------------+----------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready      | tuser: cmd; tdata: row, col, kind
//  m_axis   | out | m_axis_tvalid/tready      | tuser: status; tdata: row, col, fails
//  cfg      | in  | cfg_valid_i/cfg_ready_o   | cfg_addr_i register index, cfg_data_i
//
// Write, restart and unknown commands complete when accepted; their result is loaded
// at the accept edge. A step runs through the accept cycle, one grid read of the
// current cell (a step at the goal ends there), one grid read per neighbor tried
// (up to four, one grid read port), and one more stack read when it pops or the
// stack is full.
// After reset a clearing pass writes every grid entry open, all 2**(2*clog2(GRID_SIDE))
// of them (256 at the default); no beat is taken meanwhile, config writes are.
// A new beat is taken only while the output register is empty or draining.
`default_nettype none

module maze_stack_walker_core import msw_pkg::*; #(
  parameter int unsigned GRID_SIDE   = 16,
  parameter int unsigned STACK_DEPTH = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [3:0] cell_row, [7:4] cell_col, [9:8] cell_kind
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] cmd
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata,  // [3:0] pos_row, [7:4] pos_col, [23:8] fail_count
  output logic      [1:0]  m_axis_tuser,  // [1:0] status
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [4:0]  cfg_data_i
);

  localparam int unsigned RW   = $clog2(GRID_SIDE);
  localparam int unsigned AW   = 2 * RW;
  localparam int unsigned GDEP = 1 << AW;
  localparam int unsigned SAW  = $clog2(STACK_DEPTH);
  localparam int unsigned SCW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CMPW = (RW + 1 > 5) ? RW + 1 : 5;

  typedef struct packed {
    logic          inb;
    logic [AW-1:0] addr;
  } nb_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CUR,
    S_NB,
    S_TOP
  } state_e;

  // Neighbor address and in-bounds flag for one direction
  function automatic nb_t nb_of(input logic [1:0] dir, input logic [RW-1:0] r,
                                input logic [RW-1:0] c, input logic [CMPW-1:0] rl,
                                input logic [CMPW-1:0] cl);
    logic [CMPW-1:0] nr;
    logic [CMPW-1:0] nc;
    logic            border;
    nb_t             res;
    nr     = CMPW'(r);
    nc     = CMPW'(c);
    border = 1'b0;
    case (dir)
      DIR_UP: begin
        border = (r == '0);
        nr     = CMPW'(r) - CMPW'(1);
      end
      DIR_DOWN: begin
        nr = CMPW'(r) + CMPW'(1);
      end
      DIR_LEFT: begin
        border = (c == '0);
        nc     = CMPW'(c) - CMPW'(1);
      end
      default: begin
        nc = CMPW'(c) + CMPW'(1);
      end
    endcase
    res.inb  = !border && (nr < rl) && (nc < cl);
    res.addr = {nr[RW-1:0], nc[RW-1:0]};
    return res;
  endfunction

  state_e state_q, state_d;
  logic [AW-1:0]     clr_idx_q, clr_idx_d;
  logic [RW-1:0]     row_q, row_d, col_q, col_d;
  logic [SCW-1:0]    cnt_q, cnt_d;
  logic [FAIL_W-1:0] fails_q, fails_d;
  logic [1:0]        nb_idx_q, nb_idx_d;
  logic [3:0]        start_row_q, start_row_d, start_col_q, start_col_d;
  logic [4:0]        rows_q, rows_d, cols_q, cols_d;
  logic              out_valid_q, out_valid_d;
  logic [3:0]        out_row_q, out_row_d, out_col_q, out_col_d;
  logic [FAIL_W-1:0] out_fails_q, out_fails_d;
  logic [1:0]        out_st_q, out_st_d;

  logic            g_we;
  logic [AW-1:0]   g_waddr, g_raddr;
  logic [1:0]      g_wdata, g_rdata;
  logic            s_we;
  logic [SAW-1:0]  s_waddr, s_raddr;
  logic [AW-1:0]   s_rdata;

  logic            in_acc;
  cmd_e            cmd;
  logic [3:0]      in_row, in_col;
  logic [1:0]      in_kind;
  logic [CMPW-1:0] rl, cl, srow_e, scol_e, lim_e;
  logic [1:0]      issue_dir;
  nb_t             nb_eval, nb_issue;
  logic            nb_open, emit;
  logic [1:0]      emit_st;

  assign in_row  = s_axis_tdata[3:0];
  assign in_col  = s_axis_tdata[7:4];
  assign in_kind = s_axis_tdata[9:8];
  assign cmd     = cmd_e'(s_axis_tuser);

  assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Bounds, saturated to the grid size
  assign rl = (CMPW'(rows_q) > CMPW'(GRID_SIDE)) ? CMPW'(GRID_SIDE) : CMPW'(rows_q);
  assign cl = (CMPW'(cols_q) > CMPW'(GRID_SIDE)) ? CMPW'(GRID_SIDE) : CMPW'(cols_q);
  assign lim_e  = CMPW'(GRID_SIDE - 1);
  assign srow_e = (CMPW'(start_row_q) > lim_e) ? lim_e : CMPW'(start_row_q);
  assign scol_e = (CMPW'(start_col_q) > lim_e) ? lim_e : CMPW'(start_col_q);

  // Neighbor being checked this cycle and neighbor whose read is issued
  assign issue_dir = (state_q == S_CUR) ? DIR_UP : nb_idx_q + 2'd1;
  assign nb_eval   = nb_of(nb_idx_q, row_q, col_q, rl, cl);
  assign nb_issue  = nb_of(issue_dir, row_q, col_q, rl, cl);
  assign nb_open   = nb_eval.inb && (g_rdata == KIND_OPEN || g_rdata == KIND_GOAL);

  // Stack is always read at its top entry
  assign s_raddr = SAW'(cnt_q - SCW'(1));
  assign s_waddr = cnt_q[SAW-1:0];

  // Sequencer and memory control
  always_comb begin
    state_d     = state_q;
    clr_idx_d   = clr_idx_q;
    row_d       = row_q;
    col_d       = col_q;
    cnt_d       = cnt_q;
    fails_d     = fails_q;
    nb_idx_d    = nb_idx_q;
    start_row_d = start_row_q;
    start_col_d = start_col_q;
    rows_d      = rows_q;
    cols_d      = cols_q;
    emit        = 1'b0;
    emit_st     = ST_ACK;
    g_we        = 1'b0;
    g_waddr     = {row_q, col_q};
    g_wdata     = KIND_VISITED;
    g_raddr     = nb_issue.addr;
    s_we        = 1'b0;

    if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CFG_START_ROW: start_row_d = cfg_data_i[3:0];
        CFG_START_COL: start_col_d = cfg_data_i[3:0];
        CFG_ROWS:      rows_d      = cfg_data_i;
        default:       cols_d      = cfg_data_i;
      endcase
    end

    unique case (state_q)
      S_CLEAR: begin
        g_we      = 1'b1;
        g_waddr   = clr_idx_q;
        g_wdata   = KIND_OPEN;
        clr_idx_d = clr_idx_q + AW'(1);
        if (clr_idx_q == AW'(GDEP - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        g_raddr = {row_q, col_q};
        if (in_acc) begin
          unique case (cmd)
            CMD_WRITE: begin
              emit = 1'b1;
              if (CMPW'(in_row) < CMPW'(GRID_SIDE) && CMPW'(in_col) < CMPW'(GRID_SIDE)) begin
                g_we    = 1'b1;
                g_waddr = {RW'(in_row), RW'(in_col)};
                g_wdata = in_kind;
              end
            end
            CMD_STEP: begin
              state_d = S_CUR;
            end
            CMD_RESTART: begin
              emit    = 1'b1;
              cnt_d   = '0;
              fails_d = '0;
              row_d   = srow_e[RW-1:0];
              col_d   = scol_e[RW-1:0];
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_CUR: begin
        if (g_rdata == KIND_GOAL) begin
          emit    = 1'b1;
          emit_st = ST_GOAL;
          state_d = S_IDLE;
        end else begin
          g_we     = 1'b1;
          nb_idx_d = DIR_UP;
          state_d  = S_NB;
        end
      end
      S_NB: begin
        if (nb_open) begin
          if (cnt_q < SCW'(STACK_DEPTH)) begin
            s_we    = 1'b1;
            cnt_d   = cnt_q + SCW'(1);
            row_d   = nb_eval.addr[AW-1:RW];
            col_d   = nb_eval.addr[RW-1:0];
            emit    = 1'b1;
            emit_st = ST_MOVED;
            state_d = S_IDLE;
          end else begin
            state_d = S_TOP;
          end
        end else if (nb_idx_q == DIR_RIGHT) begin
          if (cnt_q == '0) begin
            emit    = 1'b1;
            emit_st = ST_NO_PATH;
            state_d = S_IDLE;
          end else begin
            cnt_d   = cnt_q - SCW'(1);
            if (fails_q != '1) begin
              fails_d = fails_q + FAIL_W'(1);
            end
            state_d = S_TOP;
          end
        end else begin
          nb_idx_d = nb_idx_q + 2'd1;
        end
      end
      S_TOP: begin
        row_d   = s_rdata[AW-1:RW];
        col_d   = s_rdata[RW-1:0];
        emit    = 1'b1;
        emit_st = ST_MOVED;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_fails_d = out_fails_q;
    out_st_d    = out_st_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_row_d   = 4'(row_d);
      out_col_d   = 4'(col_d);
      out_fails_d = fails_d;
      out_st_d    = emit_st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_idx_q   <= '0;
      row_q       <= '0;
      col_q       <= '0;
      cnt_q       <= '0;
      fails_q     <= '0;
      nb_idx_q    <= DIR_UP;
      start_row_q <= '0;
      start_col_q <= '0;
      rows_q      <= 5'd16;
      cols_q      <= 5'd16;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      row_q       <= row_d;
      col_q       <= col_d;
      cnt_q       <= cnt_d;
      fails_q     <= fails_d;
      nb_idx_q    <= nb_idx_d;
      start_row_q <= start_row_d;
      start_col_q <= start_col_d;
      rows_q      <= rows_d;
      cols_q      <= cols_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload needs no reset
  always_ff @(posedge clk_i) begin
    out_row_q   <= out_row_d;
    out_col_q   <= out_col_d;
    out_fails_q <= out_fails_d;
    out_st_q    <= out_st_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_fails_q, out_col_q, out_row_q};
  assign m_axis_tuser  = out_st_q;

  // Grid cell kinds
  msw_ram #(
    .WIDTH (2),
    .DEPTH (GDEP)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (g_wdata),
    .raddr_i (g_raddr),
    .rdata_o (g_rdata)
  );

  // Path stack of cell addresses
  msw_ram #(
    .WIDTH (AW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (nb_eval.addr),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/msw_checker.sv =====
// Port-level checks for the maze walker, bound to the top level.
`default_nettype none

module msw_checker import msw_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  // A stalled result beat stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result payload changed while stalled");

  // No input beat is taken while a result is stuck in the output register
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid && !m_axis_tready))
    else $error("input taken while output blocked");

  // A cell write is acknowledged on the next cycle
  a_write_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_WRITE
    |=> m_axis_tvalid && m_axis_tuser == ST_ACK)
    else $error("cell write not acknowledged");

endmodule

bind maze_stack_walker_core msw_checker u_msw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== tb/tb_maze_stack_walker_core.sv =====
// Self-checking testbench for the maze stack walker core: walk scenarios checked by a model.
`default_nettype none

module tb_maze_stack_walker_core;
  import msw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_N       = 16;
  localparam int STACK_N      = 256;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 12;
  localparam int FAIL_ROUNDS  = 5;
  localparam int PHASE_BEATS  = 90;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [3:0]  row;
    logic [3:0]  col;
    logic [15:0] fails;
    logic [1:0]  status;
  } walk_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_addr_i    = '0;
  logic [4:0]  cfg_data_i    = '0;

  // Walker model state
  logic [1:0]  maze_q [GRID_N*GRID_N];
  logic [7:0]  path_mem [STACK_N];
  int          path_depth;
  logic [7:0]  walker_pos;
  logic [15:0] fail_tally;
  logic [3:0]  start_row_q;
  logic [3:0]  start_col_q;
  logic [4:0]  rows_lim_q;
  logic [4:0]  cols_lim_q;

  walk_result_t pending_results [$];
  walk_result_t want_beat;
  walk_result_t seen_beat;

  int unsigned err_count  = 0;
  int unsigned beats_sent = 0;
  int          src_gap_pct    = 0;
  int          sink_stall_pct = 0;
  bit          hold_request   = 1'b0;
  int          hold_left      = 0;

  maze_stack_walker_core #(
    .GRID_SIDE  (GRID_N),
    .STACK_DEPTH(STACK_N)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [3:0] cell_row, [7:4] cell_col, [9:8] cell_kind
    .s_axis_tuser (s_axis_tuser),   // [1:0] cmd
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [3:0] pos_row, [7:4] pos_col, [23:8] fail_count
    .m_axis_tuser (m_axis_tuser),   // [1:0] status
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Hard stop if the run hangs
  initial begin
    #(5_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  // Result-side ready: long hold-off on request, else random stalls
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Check every result beat against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      seen_beat.row    = m_axis_tdata[3:0];
      seen_beat.col    = m_axis_tdata[7:4];
      seen_beat.fails  = m_axis_tdata[23:8];
      seen_beat.status = m_axis_tuser;
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected beat, expected none, got %0d/%0d/%0d/%0d", $time,
                 seen_beat.row, seen_beat.col, seen_beat.fails, seen_beat.status);
      end else begin
        want_beat = pending_results.pop_front();
        if (seen_beat.row !== want_beat.row || seen_beat.col !== want_beat.col ||
            seen_beat.fails !== want_beat.fails || seen_beat.status !== want_beat.status) begin
          err_count++;
          // fields as row/col/fails/status
          $display("%0t: mismatch, expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                   $time, want_beat.row, want_beat.col, want_beat.fails, want_beat.status,
                   seen_beat.row, seen_beat.col, seen_beat.fails, seen_beat.status);
        end
      end
    end
  end

  task automatic reset_walker_model();
    for (int i = 0; i < GRID_N*GRID_N; i++) maze_q[i] = KIND_OPEN;
    for (int i = 0; i < STACK_N; i++) path_mem[i] = '0;
    path_depth  = 0;
    walker_pos  = '0;
    fail_tally  = '0;
    start_row_q = '0;
    start_col_q = '0;
    rows_lim_q  = 5'd16;
    cols_lim_q  = 5'd16;
  endtask

  // Take a neighbor if nothing is taken yet and it lies in bounds and is open or goal
  function automatic void try_neighbor(input int r, input int c, input int rl, input int cl,
                                       inout bit found, inout logic [7:0] nb);
    logic [1:0] k;
    if (found || r < 0 || c < 0 || r >= rl || c >= cl) return;
    k = maze_q[{r[3:0], c[3:0]}];
    if (k == KIND_WALL || k == KIND_VISITED) return;
    found = 1'b1;
    nb = {r[3:0], c[3:0]};
  endfunction

  // Advance the walker model by one accepted beat and queue its result
  function automatic void predict_walk(input logic [1:0] cmd, input logic [3:0] wr,
                                       input logic [3:0] wc, input logic [1:0] kind);
    int rl;
    int cl;
    int r;
    int c;
    bit found;
    logic [7:0] nb;
    logic [1:0] st;
    walk_result_t res;
    rl = (int'(rows_lim_q) > GRID_N) ? GRID_N : int'(rows_lim_q);
    cl = (int'(cols_lim_q) > GRID_N) ? GRID_N : int'(cols_lim_q);
    st = ST_ACK;
    found = 1'b0;
    nb = '0;
    if (cmd == CMD_WRITE) begin
      maze_q[{wr, wc}] = kind;
    end else if (cmd == CMD_RESTART) begin
      path_depth = 0;
      fail_tally = '0;
      walker_pos = {start_row_q, start_col_q};
    end else if (cmd == CMD_STEP) begin
      if (maze_q[walker_pos] == KIND_GOAL) begin
        st = ST_GOAL;
      end else begin
        maze_q[walker_pos] = KIND_VISITED;
        r = int'(walker_pos[7:4]);
        c = int'(walker_pos[3:0]);
        try_neighbor(r - 1, c, rl, cl, found, nb);
        try_neighbor(r + 1, c, rl, cl, found, nb);
        try_neighbor(r, c - 1, rl, cl, found, nb);
        try_neighbor(r, c + 1, rl, cl, found, nb);
        // a full stack drops the push but the walker still goes to the top
        if (found && path_depth < STACK_N) begin
          path_mem[path_depth] = nb;
          path_depth++;
        end
        if (path_depth == 0) begin
          st = ST_NO_PATH;
        end else if (!found) begin
          st = ST_MOVED;
          path_depth--;
          walker_pos = path_mem[path_depth];
          if (fail_tally != 16'hFFFF) fail_tally++;
        end else begin
          st = ST_MOVED;
          walker_pos = path_mem[path_depth - 1];
        end
      end
    end
    res.row    = walker_pos[7:4];
    res.col    = walker_pos[3:0];
    res.fails  = fail_tally;
    res.status = st;
    pending_results.push_back(res);
  endfunction

  // Offer one input beat, with a random gap first, and predict it once taken
  task automatic send_beat(input logic [1:0] cmd, input logic [3:0] row,
                           input logic [3:0] col, input logic [1:0] kind);
    while (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, kind, col, row};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_walk(cmd, row, col, kind);
    beats_sent++;
  endtask

  // Stop offering and wait until every expected beat has arrived
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [4:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (addr)
      CFG_START_ROW: start_row_q = value[3:0];
      CFG_START_COL: start_col_q = value[3:0];
      CFG_ROWS:      rows_lim_q  = value;
      CFG_COLS:      cols_lim_q  = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_walk_area(input logic [4:0] sr, input logic [4:0] sc,
                               input logic [4:0] nr, input logic [4:0] nc);
    drain_results();
    write_reg(CFG_START_ROW, sr);
    write_reg(CFG_START_COL, sc);
    write_reg(CFG_ROWS, nr);
    write_reg(CFG_COLS, nc);
  endtask

  function automatic logic [3:0] near(input logic [3:0] v);
    return v + 4'($urandom_range(4)) - 4'd2;
  endfunction

  // Mostly open cells, some walls, few goals and visited marks
  function automatic logic [1:0] maze_kind();
    int pick;
    pick = $urandom_range(9);
    if (pick < 5) return KIND_OPEN;
    if (pick < 8) return KIND_WALL;
    if (pick == 8) return KIND_GOAL;
    return KIND_VISITED;
  endfunction

  function automatic logic [4:0] pick_bound();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 5'd0;
    if (pick == 1) return 5'($urandom_range(31, 17));
    return 5'($urandom_range(16, 1));
  endfunction

  // Snake over the open grid fills the stack, then push past full and pop
  task automatic test_stack_full();
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    send_beat(CMD_RESTART, 4'd0, 4'd0, KIND_OPEN);
    repeat (255) send_beat(CMD_STEP, 4'd0, 4'd0, KIND_OPEN);
    send_beat(CMD_WRITE, 4'd1, 4'd15, KIND_OPEN);
    send_beat(CMD_STEP, 4'd0, 4'd0, KIND_OPEN);
    send_beat(CMD_WRITE, 4'd0, 4'd15, KIND_OPEN);
    send_beat(CMD_STEP, 4'd0, 4'd0, KIND_OPEN);
    send_beat(CMD_WRITE, 4'd0, 4'd15, KIND_WALL);
    repeat (4) send_beat(CMD_STEP, 4'd0, 4'd0, KIND_OPEN);
    drain_results();
  endtask

  // Goal reached and held, field extremes, unknown command, no path, dead-end pop
  task automatic test_directed();
    send_beat(CMD_WRITE, 4'd0, 4'd0, KIND_OPEN);
    send_beat(CMD_WRITE, 4'd0, 4'd1, KIND_GOAL);
    send_beat(CMD_WRITE, 4'd1, 4'd0, KIND_WALL);
    send_beat(CMD_WRITE, 4'd1, 4'd1, KIND_WALL);
    send_beat(CMD_WRITE, 4'd0, 4'd2, KIND_WALL);
    send_beat(CMD_RESTART, 4'd15, 4'd15, KIND_GOAL);
    send_beat(CMD_STEP, 4'd0, 4'd0, KIND_OPEN);
    send_beat(CMD_STEP, 4'd15, 4'd15, KIND_GOAL);
    send_beat(CMD_STEP, 4'd0, 4'd0, KIND_OPEN);
    send_beat(CMD_WRITE, 4'd15, 4'd15, KIND_WALL);
    send_beat(CMD_WRITE, 4'd15, 4'd15, KIND_VISITED);
    send_beat(CMD_UNKNOWN, 4'd15, 4'd15, KIND_GOAL);
    send_beat(CMD_WRITE, 4'd0, 4'd1, KIND_WALL);
    send_beat(CMD_RESTART, 4'd0, 4'd0, KIND_OPEN);
    send_beat(CMD_STEP, 4'd0, 4'd0, KIND_OPEN);
    send_beat(CMD_STEP, 4'd0, 4'd0, KIND_OPEN);
    send_beat(CMD_WRITE, 4'd0, 4'd1, KIND_OPEN);
    send_beat(CMD_STEP, 4'd0, 4'd0, KIND_OPEN);
    send_beat(CMD_STEP, 4'd0, 4'd0, KIND_OPEN);
    send_beat(CMD_STEP, 4'd0, 4'd0, KIND_OPEN);
    send_beat(CMD_UNKNOWN, 4'd0, 4'd0, KIND_OPEN);
    drain_results();
  endtask

  // Zero bounds, bounds above the grid, start at the far corner, a tiny grid
  task automatic test_bounds();
    set_walk_area(5'd31, 5'd16, 5'd0, 5'd0);
    send_beat(CMD_WRITE, 4'd15, 4'd0, KIND_OPEN);
    send_beat(CMD_RESTART, 4'd0, 4'd0, KIND_OPEN);
    send_beat(CMD_STEP, 4'd0, 4'd0, KIND_OPEN);
    set_walk_area(5'd15, 5'd15, 5'd31, 5'd31);
    send_beat(CMD_WRITE, 4'd15, 4'd15, KIND_OPEN);
    send_beat(CMD_WRITE, 4'd14, 4'd15, KIND_OPEN);
    send_beat(CMD_WRITE, 4'd15, 4'd14, KIND_OPEN);
    send_beat(CMD_RESTART, 4'd0, 4'd0, KIND_OPEN);
    repeat (3) send_beat(CMD_STEP, 4'd0, 4'd0, KIND_OPEN);
    set_walk_area(5'd0, 5'd0, 5'd1, 5'd2);
    send_beat(CMD_WRITE, 4'd0, 4'd0, KIND_OPEN);
    send_beat(CMD_WRITE, 4'd0, 4'd1, KIND_OPEN);
    send_beat(CMD_WRITE, 4'd1, 4'd0, KIND_OPEN);
    send_beat(CMD_RESTART, 4'd0, 4'd0, KIND_OPEN);
    repeat (3) send_beat(CMD_STEP, 4'd0, 4'd0, KIND_OPEN);
    drain_results();
  endtask

  // Two-cell corridor: reopen, push, pop for a few rounds of fail counting
  task automatic test_fail_count();
    set_walk_area(5'd0, 5'd0, 5'd2, 5'd1);
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    send_beat(CMD_WRITE, 4'd0, 4'd0, KIND_OPEN);
    send_beat(CMD_RESTART, 4'd0, 4'd0, KIND_OPEN);
    for (int i = 0; i < FAIL_ROUNDS; i++) begin
      if (walker_pos == 8'h00) send_beat(CMD_WRITE, 4'd1, 4'd0, KIND_OPEN);
      else send_beat(CMD_WRITE, 4'd0, 4'd0, KIND_OPEN);
      send_beat(CMD_STEP, 4'd0, 4'd0, KIND_OPEN);
      send_beat(CMD_STEP, 4'd0, 4'd0, KIND_OPEN);
    end
    drain_results();
  endtask

  // Sink holds off for a long stretch while beats keep coming
  task automatic test_backpressure();
    set_walk_area(5'd3, 5'd3, 5'd16, 5'd16);
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    @(posedge clk_i);
    hold_request = 1'b1;
    send_beat(CMD_RESTART, 4'd0, 4'd0, KIND_OPEN);
    repeat (30) begin
      if ($urandom_range(1) == 0)
        send_beat(CMD_WRITE, near(walker_pos[7:4]), near(walker_pos[3:0]), maze_kind());
      else
        send_beat(CMD_STEP, 4'($urandom), 4'($urandom), 2'($urandom));
    end
    drain_results();
  endtask

  // Random maze edits around the walker, an optional restart, then a run of mostly steps
  task automatic walk_episode();
    int n;
    int pick;
    n = $urandom_range(8, 1);
    repeat (n) send_beat(CMD_WRITE, near(walker_pos[7:4]), near(walker_pos[3:0]), maze_kind());
    if ($urandom_range(4) == 0)
      send_beat(CMD_RESTART, 4'($urandom), 4'($urandom), 2'($urandom));
    n = $urandom_range(16, 2);
    repeat (n) begin
      pick = $urandom_range(19);
      if (pick == 0) send_beat(CMD_UNKNOWN, 4'($urandom), 4'($urandom), 2'($urandom));
      else if (pick == 1) send_beat(CMD_WRITE, 4'($urandom), 4'($urandom), 2'($urandom));
      else send_beat(CMD_STEP, 4'($urandom), 4'($urandom), 2'($urandom));
    end
  endtask

  task automatic test_random_walks();
    int target;
    for (int phase = 0; phase < 4; phase++) begin
      set_walk_area(5'($urandom_range(31)), 5'($urandom_range(31)), pick_bound(),
                    pick_bound());
      case (phase)
        0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_gap_pct = 47; sink_stall_pct = 0;  end
        2: begin src_gap_pct = 0;  sink_stall_pct = 47; end
        default: begin src_gap_pct = 28; sink_stall_pct = 28; end
      endcase
      send_beat(CMD_RESTART, 4'($urandom), 4'($urandom), 2'($urandom));
      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) walk_episode();
    end
    drain_results();
  endtask

  initial begin
    reset_walker_model();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_stack_full();
    test_directed();
    test_bounds();
    test_fail_count();
    test_backpressure();
    test_random_walks();
    drain_results();
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/msw_pkg.sv
rtl/msw_ram.sv
rtl/maze_stack_walker_core.sv
rtl/msw_checker.sv
tb/tb_maze_stack_walker_core.sv
